### rtl/pxf_pkg.sv
`timescale 1ns / 1ps

package pxf_pkg;

   // Position limits
   localparam int MAX_WIDTH   = 4096;
   localparam int COL_W       = 12;            // column position / block column
   localparam int ROW_W       = 12;            // band count
   localparam int BAND_ROW_W  = 4;             // row inside a band
   localparam int WIDTH_W     = 13;            // image_width register
   localparam int LG_W        = 3;             // block_side_log2 register
   localparam logic [LG_W-1:0] MAX_LG = 3'd4;
   localparam int ADDR_W      = $clog2(MAX_WIDTH);

   // Filter modes
   localparam int MODE_W = 2;
   localparam logic [MODE_W-1:0] MODE_AVG    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_DARK   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_BRIGHT = 2'd2;
   localparam logic [MODE_W-1:0] MODE_SPARE  = 2'd3;

   // Luminance: floor((299R + 587G + 114B) / 1000)
   // weighted sum is below 2^18; divide by 1000 as (x * 134218) >> 27, exact for x <= 255000
   localparam int WSUM_W = 18;
   localparam logic [WSUM_W-1:0] LUMA_R_WT = 18'd299;
   localparam logic [WSUM_W-1:0] LUMA_G_WT = 18'd587;
   localparam logic [WSUM_W-1:0] LUMA_B_WT = 18'd114;
   localparam int LUMA_PROD_W = 2 * WSUM_W;
   localparam logic [WSUM_W-1:0] LUMA_RECIP = 18'd134218;
   localparam int LUMA_SHIFT = 27;

   localparam int CH_W  = 8;
   localparam int SUM_W = 16;

   typedef struct packed {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
   } color_type;

   // One per-block-column entry of the band store
   typedef struct packed {
      logic [SUM_W-1:0] red_sum;
      logic [SUM_W-1:0] green_sum;
      logic [SUM_W-1:0] blue_sum;
      logic [CH_W-1:0]  best_luma;
      color_type        best_color;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // Where the current pixel sits
   typedef struct packed {
      logic [COL_W-1:0] column;   // block column
      logic [ROW_W-1:0] row;      // block row (band count)
      logic             first;    // first pixel of its block
      logic             last;     // last pixel of its block
   } pos_type;

   // Pixel held between the input register and the result register
   typedef struct packed {
      pos_type           pos;
      logic [MODE_W-1:0] mode;
      logic [LG_W-1:0]   lg;
      color_type         color;
      logic [WSUM_W-1:0] wsum;
   } stage_type;

endpackage

### rtl/pxf_ram.sv
`timescale 1ns / 1ps

module pxf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/pxf_track.sv
`timescale 1ns / 1ps

module pxf_track (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  logic                       frame_start,
   input  logic [pxf_pkg::LG_W-1:0]   lg,
   input  logic [pxf_pkg::WIDTH_W-1:0] image_width,
   output pxf_pkg::pos_type           pos
);

   import pxf_pkg::*;

   logic [COL_W-1:0]      column_position_ff, column_position_in;
   logic [BAND_ROW_W-1:0] row_in_band_ff, row_in_band_in;
   logic [ROW_W-1:0]      band_count_ff, band_count_in;

   logic [COL_W-1:0]      cur_col;
   logic [BAND_ROW_W-1:0] cur_row;
   logic [ROW_W-1:0]      cur_band;
   logic [BAND_ROW_W-1:0] side_mask;
   logic [COL_W-1:0]      side_mask_col;
   logic [WIDTH_W-1:0]    width_eff;
   logic                  row_end;

   always_comb begin
      // frame_start clears the counters ahead of this pixel
      cur_col  = frame_start ? '0 : column_position_ff;
      cur_row  = frame_start ? '0 : row_in_band_ff;
      cur_band = frame_start ? '0 : band_count_ff;

      side_mask     = BAND_ROW_W'((5'd1 << lg) - 5'd1);
      side_mask_col = COL_W'(side_mask);

      if (image_width == '0 || image_width > WIDTH_W'(MAX_WIDTH)) begin
         width_eff = WIDTH_W'(MAX_WIDTH);
      end else begin
         width_eff = image_width;
      end

      pos.column = cur_col >> lg;
      pos.row    = cur_band;
      pos.first  = (cur_row == '0) && ((cur_col & side_mask_col) == '0);
      pos.last   = (cur_row == side_mask) && ((cur_col & side_mask_col) == side_mask_col);

      row_end = {1'b0, cur_col} >= (width_eff - WIDTH_W'(1));

      column_position_in = cur_col + COL_W'(1);
      row_in_band_in     = cur_row;
      band_count_in      = cur_band;
      if (row_end) begin
         column_position_in = '0;
         if (cur_row >= side_mask) begin
            row_in_band_in = '0;
            band_count_in  = cur_band + ROW_W'(1);
         end else begin
            row_in_band_in = cur_row + BAND_ROW_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_position_ff <= '0;
         row_in_band_ff     <= '0;
         band_count_ff      <= '0;
      end else if (advance) begin
         column_position_ff <= column_position_in;
         row_in_band_ff     <= row_in_band_in;
         band_count_ff      <= band_count_in;
      end
   end

endmodule

### rtl/pxf_blend.sv
`timescale 1ns / 1ps

module pxf_blend (
   input  pxf_pkg::stage_type stage,
   input  pxf_pkg::entry_type old_entry,
   output pxf_pkg::entry_type new_entry,
   output pxf_pkg::color_type block_color
);

   import pxf_pkg::*;

   logic [LUMA_PROD_W-1:0] luma_prod;
   logic [CH_W-1:0]        luma;
   entry_type              base;
   logic [3:0]             avg_shift;

   always_comb begin
      luma_prod = LUMA_PROD_W'(stage.wsum) * LUMA_PROD_W'(LUMA_RECIP);
      luma      = luma_prod[LUMA_SHIFT +: CH_W];

      // starting point: stored entry, or a fresh block
      base = old_entry;
      if (stage.pos.first) begin
         base.red_sum   = '0;
         base.green_sum = '0;
         base.blue_sum  = '0;
         if (stage.mode == MODE_DARK) begin
            base.best_luma  = luma;
            base.best_color = stage.color;
         end else begin
            base.best_luma  = '0;
            base.best_color = '0;
         end
      end

      new_entry = base;
      case (stage.mode)
         MODE_DARK: begin
            if (luma < base.best_luma) begin
               new_entry.best_luma  = luma;
               new_entry.best_color = stage.color;
            end
         end
         MODE_BRIGHT: begin
            if (luma > base.best_luma) begin
               new_entry.best_luma  = luma;
               new_entry.best_color = stage.color;
            end
         end
         default: begin
            new_entry.red_sum   = base.red_sum + SUM_W'(stage.color.red);
            new_entry.green_sum = base.green_sum + SUM_W'(stage.color.green);
            new_entry.blue_sum  = base.blue_sum + SUM_W'(stage.color.blue);
         end
      endcase

      avg_shift = {stage.lg[2:0], 1'b0};
      if (stage.mode == MODE_DARK || stage.mode == MODE_BRIGHT) begin
         block_color = new_entry.best_color;
      end else begin
         block_color.red   = CH_W'(new_entry.red_sum >> avg_shift);
         block_color.green = CH_W'(new_entry.green_sum >> avg_shift);
         block_color.blue  = CH_W'(new_entry.blue_sum >> avg_shift);
      end
   end

endmodule

### rtl/block_pixelate_filter_unit.sv
`timescale 1ns / 1ps

// Channel   Dir   Handshake              Payload
// req       in    req_valid/req_stall    frame_start, pixel_red/green/blue
// rsp       out   rsp_valid/rsp_stall    block_red/green/blue, block_column, block_row
// csr       in    psel/penable/pwrite    paddr[3:2] = register, pwdata/prdata 32 bits
//
// One pixel per cycle sustained while req_stall is low.
// Pixel path: input stage (position, luma weighted sum, store read issued), then
// the update stage (store entry merged, luma divide, write back) into the result register.
// Throughput is set by the single read-modify-write of the per-column store each cycle.
// Synchronous reset clears counters and valid flags; the store is not cleared.
// req_stall rises only when the update stage holds a finished block and rsp is stalled.

module block_pixelate_filter_unit (
   input  logic                          clock,
   input  logic                          reset,
   // pixel input
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_frame_start,
   input  logic [7:0]                    req_pixel_red,
   input  logic [7:0]                    req_pixel_green,
   input  logic [7:0]                    req_pixel_blue,
   // block result
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [7:0]                    rsp_block_red,
   output logic [7:0]                    rsp_block_green,
   output logic [7:0]                    rsp_block_blue,
   output logic [11:0]                   rsp_block_column,
   output logic [11:0]                   rsp_block_row,
   // configuration
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [3:0]                    paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);

   import pxf_pkg::*;

   localparam logic [1:0] REG_FILTER_MODE = 2'd0;
   localparam logic [1:0] REG_SIDE_LOG2   = 2'd1;
   localparam logic [1:0] REG_WIDTH       = 2'd2;

   // ---------------- configuration registers ----------------
   logic [MODE_W-1:0]  filter_mode_ff;
   logic [LG_W-1:0]    block_side_log2_ff;
   logic [WIDTH_W-1:0] image_width_ff;
   logic               csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_mode_ff     <= MODE_AVG;
         block_side_log2_ff <= LG_W'(1);
         image_width_ff     <= WIDTH_W'(640);
      end else if (csr_write) begin
         unique case (paddr[3:2])
            REG_FILTER_MODE: filter_mode_ff     <= pwdata[MODE_W-1:0];
            REG_SIDE_LOG2:   block_side_log2_ff <= pwdata[LG_W-1:0];
            REG_WIDTH:       image_width_ff     <= pwdata[WIDTH_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_FILTER_MODE: prdata = 32'(filter_mode_ff);
         REG_SIDE_LOG2:   prdata = 32'(block_side_log2_ff);
         REG_WIDTH:       prdata = 32'(image_width_ff);
         default:         prdata = '0;
      endcase
   end

   // ---------------- flow control ----------------
   logic       s1_valid_ff;
   stage_type  s1_ff;
   logic       rsp_valid_ff;
   logic       out_free;
   logic       s1_move;
   logic       accept;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   // update stage drains unless it holds a finished block with nowhere to go
   assign s1_move   = !s1_valid_ff || !s1_ff.pos.last || out_free;
   assign req_stall = !s1_move;
   assign accept    = req_valid && s1_move;

   // ---------------- input stage ----------------
   logic [LG_W-1:0]   lg_eff;
   logic [MODE_W-1:0] mode_eff;
   pos_type           pos;
   stage_type         s1_in;

   assign lg_eff = (block_side_log2_ff > MAX_LG) ? MAX_LG : block_side_log2_ff;

   always_comb begin
      case (filter_mode_ff)
         MODE_DARK:   mode_eff = MODE_DARK;
         MODE_BRIGHT: mode_eff = MODE_BRIGHT;
         default:     mode_eff = MODE_AVG;   // spare code averages
      endcase
   end

   pxf_track u_track (
      .clock       (clock),
      .reset       (reset),
      .advance     (accept),
      .frame_start (req_frame_start),
      .lg          (lg_eff),
      .image_width (image_width_ff),
      .pos         (pos)
   );

   always_comb begin
      s1_in.pos         = pos;
      s1_in.mode        = mode_eff;
      s1_in.lg          = lg_eff;
      s1_in.color.red   = req_pixel_red;
      s1_in.color.green = req_pixel_green;
      s1_in.color.blue  = req_pixel_blue;
      // weighted luma sum; the divide by 1000 happens in the update stage
      s1_in.wsum = WSUM_W'(req_pixel_red) * LUMA_R_WT
                 + WSUM_W'(req_pixel_green) * LUMA_G_WT
                 + WSUM_W'(req_pixel_blue) * LUMA_B_WT;
   end

   // ---------------- per-column store ----------------
   entry_type        ram_rd_entry;
   logic [ENTRY_W-1:0] ram_rd_data;
   entry_type        new_entry;
   logic             ram_wr_en;
   logic             bypass_in;
   logic             bypass_ff;
   entry_type        bypass_data_ff;
   entry_type        old_entry;
   color_type        block_color;

   assign ram_wr_en = s1_valid_ff && s1_move;

   pxf_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_WIDTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (s1_ff.pos.column[ADDR_W-1:0]),
      .wr_data (new_entry),
      .rd_en   (accept),
      .rd_addr (pos.column[ADDR_W-1:0]),
      .rd_data (ram_rd_data)
   );

   assign ram_rd_entry = ram_rd_data;

   // back-to-back pixels of one block column: the write lands at the same edge
   // as the read, so take the freshly computed entry instead
   assign bypass_in = ram_wr_en && (s1_ff.pos.column[ADDR_W-1:0] == pos.column[ADDR_W-1:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_move) begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff          <= s1_in;
         bypass_ff      <= bypass_in;
         bypass_data_ff <= new_entry;
      end
   end

   assign old_entry = bypass_ff ? bypass_data_ff : ram_rd_entry;

   // ---------------- update stage ----------------
   pxf_blend u_blend (
      .stage       (s1_ff),
      .old_entry   (old_entry),
      .new_entry   (new_entry),
      .block_color (block_color)
   );

   // ---------------- result register ----------------
   logic       rsp_load;
   color_type  rsp_color_ff;
   logic [COL_W-1:0] rsp_column_ff;
   logic [ROW_W-1:0] rsp_row_ff;

   assign rsp_load = s1_valid_ff && s1_ff.pos.last && s1_move;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (rsp_valid_ff && rsp_stall) || rsp_load;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_color_ff  <= block_color;
         rsp_column_ff <= s1_ff.pos.column;
         rsp_row_ff    <= s1_ff.pos.row;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_block_red    = rsp_color_ff.red;
   assign rsp_block_green  = rsp_color_ff.green;
   assign rsp_block_blue   = rsp_color_ff.blue;
   assign rsp_block_column = rsp_column_ff;
   assign rsp_block_row    = rsp_row_ff;

endmodule
